@@ design/pwrfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pwrfe_pkg;

	localparam int unsigned TICK_W      = 16;
	localparam int unsigned CONFIRM_W   = 8;
	localparam int unsigned ADDR_W      = 16;
	localparam int unsigned CMD_W       = 16;
	localparam int unsigned FRAME_W     = CONFIRM_W + ADDR_W + CMD_W;
	localparam int unsigned KIND_W      = 2;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned SYM_IDX_W   = 6;

	// symbol index of the final data bit (header is index 0)
	localparam logic [SYM_IDX_W-1:0] LAST_SYM_IDX = SYM_IDX_W'(FRAME_W);

	localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ZERO   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ONE    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_HEADER_HIGH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW    = 3'd5;

	localparam logic [TICK_W-1:0] RST_HEADER_HIGH = 16'd240;
	localparam logic [TICK_W-1:0] RST_HEADER_LOW  = 16'd75;
	localparam logic [TICK_W-1:0] RST_ONE_HIGH    = 16'd35;
	localparam logic [TICK_W-1:0] RST_ONE_LOW     = 16'd15;
	localparam logic [TICK_W-1:0] RST_ZERO_HIGH   = 16'd15;
	localparam logic [TICK_W-1:0] RST_ZERO_LOW    = 16'd35;

	typedef struct packed {
		logic [TICK_W-1:0] header_high;
		logic [TICK_W-1:0] header_low;
		logic [TICK_W-1:0] one_high;
		logic [TICK_W-1:0] one_low;
		logic [TICK_W-1:0] zero_high;
		logic [TICK_W-1:0] zero_low;
	} timing_t;

	typedef struct packed {
		logic              busy;
		logic [KIND_W-1:0] kind;
		logic              last;
	} sym_ctl_t;

endpackage
`default_nettype wire

@@ design/pwrfe_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface pwrfe_req_if;
	logic                             valid;
	logic                             ready;
	logic [pwrfe_pkg::CONFIRM_W-1:0]  confirm_code;
	logic [pwrfe_pkg::ADDR_W-1:0]     remote_address;
	logic [pwrfe_pkg::CMD_W-1:0]      command_word;

	modport source (output valid, confirm_code, remote_address, command_word, input ready);
	modport sink (input valid, confirm_code, remote_address, command_word, output ready);
endinterface

interface pwrfe_sym_if;
	logic                          valid;
	logic                          ready;
	logic [pwrfe_pkg::TICK_W-1:0]  high_ticks;
	logic [pwrfe_pkg::TICK_W-1:0]  low_ticks;
	logic [pwrfe_pkg::KIND_W-1:0]  symbol_kind;
	logic                          last_symbol;

	modport source (output valid, high_ticks, low_ticks, symbol_kind, last_symbol, input ready);
	modport sink (input valid, high_ticks, low_ticks, symbol_kind, last_symbol, output ready);
endinterface
`default_nettype wire

@@ design/pwrfe_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pwrfe_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [pwrfe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pwrfe_pkg::TICK_W-1:0]      cfg_data,
	output pwrfe_pkg::timing_t                     timing
);

	pwrfe_pkg::timing_t timing_q;

	// indexes past the last register drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.header_high <= pwrfe_pkg::RST_HEADER_HIGH;
			timing_q.header_low  <= pwrfe_pkg::RST_HEADER_LOW;
			timing_q.one_high    <= pwrfe_pkg::RST_ONE_HIGH;
			timing_q.one_low     <= pwrfe_pkg::RST_ONE_LOW;
			timing_q.zero_high   <= pwrfe_pkg::RST_ZERO_HIGH;
			timing_q.zero_low    <= pwrfe_pkg::RST_ZERO_LOW;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pwrfe_pkg::REG_HEADER_HIGH: timing_q.header_high <= cfg_data;
				pwrfe_pkg::REG_HEADER_LOW:  timing_q.header_low  <= cfg_data;
				pwrfe_pkg::REG_ONE_HIGH:    timing_q.one_high    <= cfg_data;
				pwrfe_pkg::REG_ONE_LOW:     timing_q.one_low     <= cfg_data;
				pwrfe_pkg::REG_ZERO_HIGH:   timing_q.zero_high   <= cfg_data;
				pwrfe_pkg::REG_ZERO_LOW:    timing_q.zero_low    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign timing = timing_q;

endmodule
`default_nettype wire

@@ design/pwrfe_frame_shifter.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pwrfe_frame_shifter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              load,
	input  wire logic [pwrfe_pkg::FRAME_W-1:0]     frame,
	input  wire logic                              advance,
	output pwrfe_pkg::sym_ctl_t                    ctl
);

	logic                               busy_q;
	logic [pwrfe_pkg::SYM_IDX_W-1:0]    idx_q;
	logic [pwrfe_pkg::FRAME_W-1:0]      shift_q;
	logic                               at_last;

	assign at_last = (idx_q == pwrfe_pkg::LAST_SYM_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (advance) begin
			if (at_last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// header takes no frame bit; data bits leave msb first
	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= frame;
		end else if (advance && (idx_q != '0)) begin
			shift_q <= {shift_q[pwrfe_pkg::FRAME_W-2:0], 1'b0};
		end
	end

	always_comb begin
		ctl.busy = busy_q;
		ctl.last = at_last;
		if (idx_q == '0) begin
			ctl.kind = pwrfe_pkg::KIND_HEADER;
		end else if (shift_q[pwrfe_pkg::FRAME_W-1]) begin
			ctl.kind = pwrfe_pkg::KIND_ONE;
		end else begin
			ctl.kind = pwrfe_pkg::KIND_ZERO;
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= pwrfe_pkg::LAST_SYM_IDX)
		else $error("symbol index past last data bit");
	a_idle_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> idx_q == '0)
		else $error("symbol index not cleared while idle");
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && idx_q == '0)
		else $error("frame load did not start at header");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		advance && at_last && !load |=> !busy_q)
		else $error("frame did not end after last data bit");
`endif

endmodule
`default_nettype wire

@@ design/pulse_width_remote_frame_encoder_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pulse-width remote frame encoder. Each request on req (confirm code, remote
// address, command word) becomes 41 symbols on sym: one header pulse, then 40
// data bits msb first (confirm code, address, command). Every symbol carries
// its high and low durations in ticks from the timing registers, its kind
// (header, zero bit, one bit) and a last flag on the final data bit. The
// request word is held in a 40-bit shift register that moves one bit per data
// bit, so a frame is first loaded and then sent out symbol by symbol. A new
// request is taken only once the previous frame has left the shifter, and
// backpressure on sym holds a frame back, though not while it is loaded. The
// final symbol sits in the output register while the next request is taken.
// Timing registers are written through cfg_wr_en / cfg_index / cfg_data;
// indexes past the six registers are dropped.
module pulse_width_remote_frame_encoder_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [pwrfe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pwrfe_pkg::TICK_W-1:0]      cfg_data,
	pwrfe_req_if.sink                              req,
	pwrfe_sym_if.source                            sym
);

	pwrfe_pkg::timing_t   timing;
	pwrfe_pkg::sym_ctl_t  ctl;
	logic                 load;
	logic                 advance;

	logic                              out_valid_q;
	logic [pwrfe_pkg::TICK_W-1:0]      high_q;
	logic [pwrfe_pkg::TICK_W-1:0]      low_q;
	logic [pwrfe_pkg::KIND_W-1:0]      kind_q;
	logic                              last_q;

	pwrfe_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.timing    (timing)
	);

	// take a new request only once the previous frame has left the shifter
	assign req.ready = !ctl.busy;
	assign load      = req.valid && !ctl.busy;

	// advance while a frame is in progress and the output register is free or being drained
	assign advance = ctl.busy && (!out_valid_q || sym.ready);

	pwrfe_frame_shifter u_shift (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.frame   ({req.confirm_code, req.remote_address, req.command_word}),
		.advance (advance),
		.ctl     (ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (sym.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// pick the durations for the symbol kind
	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= ctl.kind;
			last_q <= ctl.last;
			case (ctl.kind)
				pwrfe_pkg::KIND_HEADER: begin
					high_q <= timing.header_high;
					low_q  <= timing.header_low;
				end
				pwrfe_pkg::KIND_ONE: begin
					high_q <= timing.one_high;
					low_q  <= timing.one_low;
				end
				default: begin
					high_q <= timing.zero_high;
					low_q  <= timing.zero_low;
				end
			endcase
		end
	end

	assign sym.valid       = out_valid_q;
	assign sym.high_ticks  = high_q;
	assign sym.low_ticks   = low_q;
	assign sym.symbol_kind = kind_q;
	assign sym.last_symbol = last_q;

`ifndef SYNTHESIS
	a_last_not_header: assert property (@(posedge clk) disable iff (!arst_n)
		sym.valid && sym.last_symbol |-> sym.symbol_kind != pwrfe_pkg::KIND_HEADER)
		else $error("header symbol flagged as last");
	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(load && advance))
		else $error("request taken while frame in progress");
	a_header_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		load ##1 advance |=> sym.valid && sym.symbol_kind == pwrfe_pkg::KIND_HEADER)
		else $error("frame did not open with header");
`endif

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import pwrfe_pkg::*;

	// Writes to these indexes land on no register and must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	// Cycles to let pass once the last symbol is out: time for a load plus the
	// output register, with margin.
	localparam int unsigned DRAIN_CYCLES = 10;
	// Cycles with no handshake on either channel before the run is called hung.
	// The longest legal quiet stretch is a long request gap plus a long symbol
	// stall plus a drain and a register burst, well under this limit.
	localparam int unsigned QUIET_LIMIT = 2000;
	// Stop printing mismatch detail past this many, but keep counting.
	localparam int unsigned MAX_REPORTS = 200;
	localparam int unsigned FRAMES_PER_PHASE = 23;
	localparam int unsigned RANDOM_PHASES = 5;

	typedef struct packed {
		logic [TICK_W-1:0] high_ticks;
		logic [TICK_W-1:0] low_ticks;
		logic [KIND_W-1:0] kind;
		logic              last;
	} pulse_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	pwrfe_req_if req_ch ();
	pwrfe_sym_if sym_ch ();

	pulse_width_remote_frame_encoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.sym       (sym_ch)
	);

	// Our own copy of the timing registers and the symbols still owed by the
	// block, oldest first.
	timing_t     timing;
	pulse_t      expected_pulses [$];
	int unsigned error_count;

	// Idle knobs: request gaps on the sender side, stalls on the symbol side.
	bit req_gaps_on;
	bit sym_stalls_on;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Mostly short idles, some medium, a few long.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 15)
			return $urandom_range(1, 3);
		else if (r < 19)
			return $urandom_range(4, 9);
		return $urandom_range(20, 60);
	endfunction

	// Field value of the given width: zero, all ones, a lone one, a lone zero,
	// or plain random.
	function automatic logic [15:0] pick_word(int unsigned width);
		logic [15:0] mask;
		int unsigned bitpos;
		mask = 16'((32'd1 << width) - 1);
		bitpos = $urandom_range(0, width - 1);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return mask;
			2: return 16'd1 << bitpos;
			3: return mask & ~(16'd1 << bitpos);
			default: return 16'($urandom) & mask;
		endcase
	endfunction

	function automatic void set_timing_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
		case (idx)
			REG_HEADER_HIGH: timing.header_high = val;
			REG_HEADER_LOW:  timing.header_low = val;
			REG_ONE_HIGH:    timing.one_high = val;
			REG_ONE_LOW:     timing.one_low = val;
			REG_ZERO_HIGH:   timing.zero_high = val;
			REG_ZERO_LOW:    timing.zero_low = val;
			default: ;
		endcase
	endfunction

	// Queue the 41 symbols of one frame: header, then the 40 frame bits msb
	// first (confirm code, address, command), last flag on the final bit only.
	function automatic void encode_frame(logic [CONFIRM_W-1:0] code,
			logic [ADDR_W-1:0] addr, logic [CMD_W-1:0] cmd);
		logic [FRAME_W-1:0] bits;
		pulse_t p;
		bits = {code, addr, cmd};
		p.high_ticks = timing.header_high;
		p.low_ticks = timing.header_low;
		p.kind = KIND_HEADER;
		p.last = 1'b0;
		expected_pulses.push_back(p);
		for (int k = FRAME_W - 1; k >= 0; k--) begin
			if (bits[k]) begin
				p.high_ticks = timing.one_high;
				p.low_ticks = timing.one_low;
				p.kind = KIND_ONE;
			end else begin
				p.high_ticks = timing.zero_high;
				p.low_ticks = timing.zero_low;
				p.kind = KIND_ZERO;
			end
			p.last = (k == 0);
			expected_pulses.push_back(p);
		end
	endfunction

	// Send one frame request. Start and end just after a falling edge; hold
	// valid high across back-to-back requests so it is never dropped and
	// raised in the same step.
	task automatic send_frame(logic [CONFIRM_W-1:0] code, logic [ADDR_W-1:0] addr,
			logic [CMD_W-1:0] cmd);
		int unsigned gap;
		gap = (req_gaps_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			// drop valid and wiggle the payload so it is seen as don't-care
			req_ch.valid <= 1'b0;
			req_ch.confirm_code <= CONFIRM_W'($urandom);
			req_ch.remote_address <= ADDR_W'($urandom);
			req_ch.command_word <= CMD_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.confirm_code <= code;
		req_ch.remote_address <= addr;
		req_ch.command_word <= cmd;
		do
			@(posedge clk);
		while (!req_ch.ready);
		encode_frame(code, addr, cmd);
		@(negedge clk);
	endtask

	// Drop the request, wait out every owed symbol, then let the block settle.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (expected_pulses.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write all six timing registers in one burst, then poke a spare index
	// with junk that must not land anywhere. Call only while idle.
	task automatic program_timing(timing_t t, logic [CFG_IDX_W-1:0] spare_idx);
		logic [CFG_IDX_W-1:0] idx_list [7];
		logic [TICK_W-1:0]    val_list [7];
		idx_list = '{REG_HEADER_HIGH, REG_HEADER_LOW, REG_ONE_HIGH, REG_ONE_LOW,
			REG_ZERO_HIGH, REG_ZERO_LOW, spare_idx};
		val_list = '{t.header_high, t.header_low, t.one_high, t.one_low,
			t.zero_high, t.zero_low, TICK_W'($urandom)};
		for (int i = 0; i < 7; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx_list[i];
			cfg_data <= val_list[i];
			@(negedge clk);
			set_timing_reg(idx_list[i], val_list[i]);
		end
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Reset timing values, no idling anywhere: field extremes, alternating bits,
	// lone set and clear bits at the ends of each field, and a random frame.
	task automatic test_reset_timing();
		req_gaps_on = 1'b0;
		sym_stalls_on = 1'b0;
		send_frame(8'h00, 16'h0000, 16'h0000);
		send_frame(8'hFF, 16'hFFFF, 16'hFFFF);
		send_frame(8'hAA, 16'h5555, 16'hAAAA);
		send_frame(8'h55, 16'hAAAA, 16'h5555);
		send_frame(8'h80, 16'h8000, 16'h8000);
		send_frame(8'h01, 16'h0001, 16'h0001);
		send_frame(8'h7F, 16'h7FFF, 16'hFFFE);
		send_frame(CONFIRM_W'($urandom), ADDR_W'($urandom), CMD_W'($urandom));
		wait_idle();
	endtask

	// Zero durations, full-scale durations, and a distinct value per register
	// so a swapped register shows up; spare indexes must be ignored.
	task automatic test_timing_registers();
		timing_t settings [3];
		logic [CFG_IDX_W-1:0] spares [3];
		settings[0] = '0;
		settings[1] = '1;
		settings[2] = '{16'h0001, 16'h0002, 16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00};
		spares = '{REG_SPARE_6, REG_SPARE_7, REG_SPARE_6};
		req_gaps_on = 1'b1;
		sym_stalls_on = 1'b1;
		for (int s = 0; s < 3; s++) begin
			program_timing(settings[s], spares[s]);
			send_frame(8'h00, 16'h0000, 16'h0000);
			send_frame(8'hFF, 16'hFFFF, 16'hFFFF);
			send_frame(CONFIRM_W'($urandom), ADDR_W'($urandom), CMD_W'($urandom));
			wait_idle();
		end
	endtask

	// Random frames in phases; each phase gets fresh random timing. The first has
	// no idling, the next two add request gaps or symbol stalls alone, the rest both.
	task automatic test_random_frames();
		timing_t t;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			t.header_high = pick_word(TICK_W);
			t.header_low = pick_word(TICK_W);
			t.one_high = pick_word(TICK_W);
			t.one_low = pick_word(TICK_W);
			t.zero_high = pick_word(TICK_W);
			t.zero_low = pick_word(TICK_W);
			program_timing(t, CFG_IDX_W'($urandom_range(REG_SPARE_6, REG_SPARE_7)));
			req_gaps_on = (ph == 1 || ph >= 3);
			sym_stalls_on = (ph >= 2);
			for (int n = 0; n < FRAMES_PER_PHASE; n++)
				send_frame(CONFIRM_W'(pick_word(CONFIRM_W)), pick_word(ADDR_W),
					pick_word(CMD_W));
			wait_idle();
		end
	endtask

	// Report one field; X on the output counts as a mismatch.
	function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
		end
	endfunction

	// Compare each accepted symbol with the oldest one owed.
	always @(posedge clk) begin : symbol_check
		pulse_t want;
		if (arst_n && sym_ch.valid && sym_ch.ready) begin
			if (expected_pulses.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: unexpected symbol: expected none, got kind %0d high %0d low %0d",
						$time, sym_ch.symbol_kind, sym_ch.high_ticks, sym_ch.low_ticks);
			end else begin
				want = expected_pulses.pop_front();
				check_field("high_ticks", want.high_ticks, sym_ch.high_ticks);
				check_field("low_ticks", want.low_ticks, sym_ch.low_ticks);
				check_field("symbol_kind", 16'(want.kind), 16'(sym_ch.symbol_kind));
				check_field("last_symbol", 16'(want.last), 16'(sym_ch.last_symbol));
			end
		end
	end

	// Symbol-side backpressure: hold ready low for random stretches when
	// stalls are enabled, otherwise keep it high.
	initial begin : sym_backpressure
		int unsigned hold;
		hold = 0;
		sym_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0 && sym_stalls_on && $urandom_range(0, 3) == 0)
				hold = idle_len();
			sym_ch.ready <= (hold == 0);
			if (hold > 0)
				hold--;
		end
	end

	// End the run if neither channel moves for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (sym_ch.valid && sym_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		// Drive every input known from time zero and hold reset.
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.confirm_code = '0;
		req_ch.remote_address = '0;
		req_ch.command_word = '0;
		req_gaps_on = 1'b0;
		sym_stalls_on = 1'b0;
		timing = '{RST_HEADER_HIGH, RST_HEADER_LOW, RST_ONE_HIGH, RST_ONE_LOW,
			RST_ZERO_HIGH, RST_ZERO_LOW};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_timing();
		test_timing_registers();
		test_random_frames();

		// Everything owed has arrived and the block has settled; any stray
		// symbol during the drain was already flagged by the checker.
		wait_idle();
		if (error_count == 0 && expected_pulses.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
